@@ hw/rtl/bfd_pkg.sv @@
// Package for the box filter downscale unit: sizes, register indexes and shared types.
// No dependencies.
package bfd_pkg;
    localparam int MaxImgDim = 256;
    localparam int MaxWindow = 16;
    localparam int DimW = 9;
    localparam int CoordW = 8;
    localparam int WinW = 5;
    localparam int PixW = 24;
    localparam int AddrW = 16;
    localparam int SumW = 16;
    localparam int AreaW = 9;
    localparam int NumW = 18;
    localparam int DenW = 10;

    localparam logic [2:0] REG_DST_WIDTH = 3'd0;
    localparam logic [2:0] REG_DST_HEIGHT = 3'd1;
    localparam logic [2:0] REG_SRC_WIDTH = 3'd2;
    localparam logic [2:0] REG_SRC_HEIGHT = 3'd3;
    localparam logic [2:0] REG_WINDOW_SIZE = 3'd4;

    typedef struct packed {
        logic load;
        logic write;
        logic corner_start;
        logic corner_y;
        logic corner_step;
        logic acc_clear;
        logic acc_read;
        logic acc_add;
        logic div_start;
        logic div_step;
        logic out_load;
    } bfd_cmd_t;

    typedef struct packed {
        logic is_write;
        logic bad;
        logic win_last;
        logic div_last;
        logic corner_last;
    } bfd_status_t;
endpackage

@@ hw/rtl/bfd_datapath.sv @@
// Datapath of the box filter downscale unit: configuration, image memory, corner and
// average dividers, window accumulators. Depends on bfd_pkg.
module bfd_datapath (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_valid,
    input  logic [2:0]                  cfg_index,
    input  logic [15:0]                 cfg_data,
    input  logic                        s_req_type,
    input  logic [bfd_pkg::CoordW-1:0]  s_coord_x,
    input  logic [bfd_pkg::CoordW-1:0]  s_coord_y,
    input  logic [bfd_pkg::PixW-1:0]    s_src_pixel,
    input  bfd_pkg::bfd_cmd_t           cmd,
    output bfd_pkg::bfd_status_t        status,
    output logic [bfd_pkg::PixW-1:0]    avg_pixel,
    output logic                        bad_coord
);
    import bfd_pkg::*;

    logic [DimW-1:0] dw_cfg_reg, dh_cfg_reg, sw_cfg_reg, sh_cfg_reg;
    logic [WinW-1:0] win_cfg_reg;
    logic [DimW-1:0] dw, dh, sw, sh;
    logic [WinW-1:0] k_sat;
    logic [WinW-1:0] k;
    logic [PixW-1:0] mem [0:MaxImgDim*MaxImgDim-1];
    logic [PixW-1:0] rd_reg;
    logic req_reg;
    logic [CoordW-1:0] x_reg, y_reg;
    logic [PixW-1:0] pix_reg;
    logic [CoordW-1:0] x0_reg, y0_reg;
    logic [WinW-1:0] m_reg, n_reg;
    logic [SumW-1:0] rs_reg, gs_reg, bs_reg;
    logic [NumW-1:0] crem_reg;
    logic [DimW-1:0] cq_reg;
    logic [3:0] ccnt_reg;
    logic [DenW-1:0] cden;
    logic [NumW:0] cshift;
    logic [NumW:0] cdiff;
    logic [DimW-1:0] climit;
    logic [CoordW-1:0] cclamp;
    logic [SumW-1:0] rq_reg, gq_reg, bq_reg;
    logic [AreaW:0] rr_reg, gr_reg, br_reg;
    logic [4:0] dcnt_reg;
    logic [AreaW-1:0] area;
    logic [PixW-1:0] avg_reg;
    logic bad_reg;
    logic [AddrW-1:0] rd_addr;
    logic [CoordW:0] ry, rx;

    function automatic logic [DimW-1:0] sat_dim(input logic [DimW-1:0] v);
        if (v == '0) begin
            return DimW'(1);
        end else if (v > DimW'(MaxImgDim)) begin
            return DimW'(MaxImgDim);
        end
        return v;
    endfunction

    function automatic logic [AreaW:0] rem_shift(input logic [AreaW:0] r,
                                                input logic b);
        return {r[AreaW-1:0], b};
    endfunction

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dw_cfg_reg <= DimW'(128);
            dh_cfg_reg <= DimW'(128);
            sw_cfg_reg <= DimW'(256);
            sh_cfg_reg <= DimW'(256);
            win_cfg_reg <= WinW'(2);
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_DST_WIDTH: dw_cfg_reg <= cfg_data[DimW-1:0];
                REG_DST_HEIGHT: dh_cfg_reg <= cfg_data[DimW-1:0];
                REG_SRC_WIDTH: sw_cfg_reg <= cfg_data[DimW-1:0];
                REG_SRC_HEIGHT: sh_cfg_reg <= cfg_data[DimW-1:0];
                REG_WINDOW_SIZE: win_cfg_reg <= cfg_data[WinW-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        dw = sat_dim(dw_cfg_reg);
        dh = sat_dim(dh_cfg_reg);
        sw = sat_dim(sw_cfg_reg);
        sh = sat_dim(sh_cfg_reg);
        k_sat = win_cfg_reg;
        if (k_sat == '0) begin
            k_sat = WinW'(1);
        end else if (k_sat > WinW'(MaxWindow)) begin
            k_sat = WinW'(MaxWindow);
        end
        k = k_sat;
        if (DimW'(k) > sw) begin
            k = sw[WinW-1:0];
        end
        if (DimW'(k) > sh) begin
            k = sh[WinW-1:0];
        end
        area = AreaW'(k) * AreaW'(k);
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            req_reg <= s_req_type;
            x_reg <= s_coord_x;
            y_reg <= s_coord_y;
            pix_reg <= s_src_pixel;
        end
    end

    assign status.is_write = !req_reg;
    assign status.bad = (DimW'(x_reg) >= dw) || (DimW'(y_reg) >= dh);

    // Corner: restoring division of 2*src*c + dst by 2*dst, one quotient bit per cycle.
    assign cden = cmd.corner_y ? {dh, 1'b0} : {dw, 1'b0};
    assign climit = cmd.corner_y ? (sh - DimW'(k)) : (sw - DimW'(k));
    assign cshift = (NumW+1)'(cden) << ccnt_reg;
    assign cdiff = {1'b0, crem_reg} - cshift;
    assign cclamp = (cq_reg > climit) ? climit[CoordW-1:0] : cq_reg[CoordW-1:0];
    assign status.corner_last = (ccnt_reg == 4'd0);

    always_ff @(posedge aclk) begin
        if (cmd.corner_start) begin
            if (cmd.corner_y) begin
                crem_reg <= NumW'({sh, 1'b0}) * NumW'(y_reg) + NumW'(dh);
            end else begin
                crem_reg <= NumW'({sw, 1'b0}) * NumW'(x_reg) + NumW'(dw);
            end
            cq_reg <= '0;
            ccnt_reg <= 4'(DimW - 1);
        end else if (cmd.corner_step) begin
            if (cdiff[NumW] == 1'b0) begin
                crem_reg <= cdiff[NumW-1:0];
                cq_reg[ccnt_reg] <= 1'b1;
            end
            ccnt_reg <= ccnt_reg - 4'd1;
        end
        if (cmd.acc_clear && cmd.corner_y) begin
            y0_reg <= cclamp;
        end else if (cmd.acc_clear) begin
            x0_reg <= cclamp;
        end
    end

    assign ry = {1'b0, y0_reg} + (CoordW+1)'(m_reg);
    assign rx = {1'b0, x0_reg} + (CoordW+1)'(n_reg);
    assign rd_addr = {ry[CoordW-1:0], rx[CoordW-1:0]};
    assign status.win_last = (m_reg == k - WinW'(1)) && (n_reg == k - WinW'(1));

    always_ff @(posedge aclk) begin
        if (cmd.write) begin
            mem[{y_reg, x_reg}] <= pix_reg;
        end
        if (cmd.acc_read) begin
            rd_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.acc_clear && !cmd.corner_y) begin
            m_reg <= '0;
            n_reg <= '0;
            rs_reg <= '0;
            gs_reg <= '0;
            bs_reg <= '0;
        end else begin
            if (cmd.acc_read) begin
                if (n_reg == k - WinW'(1)) begin
                    n_reg <= '0;
                    m_reg <= m_reg + WinW'(1);
                end else begin
                    n_reg <= n_reg + WinW'(1);
                end
            end
            if (cmd.acc_add) begin
                rs_reg <= rs_reg + SumW'(rd_reg[23:16]);
                gs_reg <= gs_reg + SumW'(rd_reg[15:8]);
                bs_reg <= bs_reg + SumW'(rd_reg[7:0]);
            end
        end
    end

    // Three restoring dividers by the window area, one quotient bit per cycle.
    assign status.div_last = (dcnt_reg == 5'd0);

    always_ff @(posedge aclk) begin
        if (cmd.div_start) begin
            rq_reg <= rs_reg;
            gq_reg <= gs_reg;
            bq_reg <= bs_reg;
            rr_reg <= '0;
            gr_reg <= '0;
            br_reg <= '0;
            dcnt_reg <= 5'(SumW - 1);
        end else if (cmd.div_step) begin
            if (rem_shift(rr_reg, rq_reg[SumW-1]) >= (AreaW+1)'(area)) begin
                rr_reg <= rem_shift(rr_reg, rq_reg[SumW-1]) - (AreaW+1)'(area);
                rq_reg <= {rq_reg[SumW-2:0], 1'b1};
            end else begin
                rr_reg <= rem_shift(rr_reg, rq_reg[SumW-1]);
                rq_reg <= {rq_reg[SumW-2:0], 1'b0};
            end
            if (rem_shift(gr_reg, gq_reg[SumW-1]) >= (AreaW+1)'(area)) begin
                gr_reg <= rem_shift(gr_reg, gq_reg[SumW-1]) - (AreaW+1)'(area);
                gq_reg <= {gq_reg[SumW-2:0], 1'b1};
            end else begin
                gr_reg <= rem_shift(gr_reg, gq_reg[SumW-1]);
                gq_reg <= {gq_reg[SumW-2:0], 1'b0};
            end
            if (rem_shift(br_reg, bq_reg[SumW-1]) >= (AreaW+1)'(area)) begin
                br_reg <= rem_shift(br_reg, bq_reg[SumW-1]) - (AreaW+1)'(area);
                bq_reg <= {bq_reg[SumW-2:0], 1'b1};
            end else begin
                br_reg <= rem_shift(br_reg, bq_reg[SumW-1]);
                bq_reg <= {bq_reg[SumW-2:0], 1'b0};
            end
            dcnt_reg <= dcnt_reg - 5'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            bad_reg <= status.bad;
            if (status.bad) begin
                avg_reg <= '0;
            end else begin
                avg_reg <= {rq_reg[7:0], gq_reg[7:0], bq_reg[7:0]};
            end
        end
    end

    assign avg_pixel = avg_reg;
    assign bad_coord = bad_reg;
endmodule

@@ hw/rtl/bfd_ctrl.sv @@
// Controller state machine of the box filter downscale unit.
// Depends on bfd_pkg.
module bfd_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    output logic                 m_valid,
    input  logic                 m_ready,
    input  bfd_pkg::bfd_status_t status,
    output bfd_pkg::bfd_cmd_t    cmd
);
    import bfd_pkg::*;

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_DECODE = 4'd1;
    localparam logic [3:0] ST_CX = 4'd2;
    localparam logic [3:0] ST_CXEND = 4'd3;
    localparam logic [3:0] ST_CY = 4'd4;
    localparam logic [3:0] ST_CYEND = 4'd5;
    localparam logic [3:0] ST_READ = 4'd6;
    localparam logic [3:0] ST_LAST = 4'd7;
    localparam logic [3:0] ST_DIV = 4'd8;
    localparam logic [3:0] ST_DIVGO = 4'd9;
    localparam logic [3:0] ST_OUT = 4'd10;
    localparam logic [3:0] ST_CYSTART = 4'd11;

    logic [3:0] state_reg, state_next;
    logic m_valid_reg, m_valid_next;
    logic rd_pend_reg;

    assign s_ready = (state_reg == ST_IDLE) && !m_valid_reg;
    assign m_valid = m_valid_reg;

    always_comb begin
        state_next = state_reg;
        m_valid_next = m_valid_reg && !m_ready;
        cmd = '0;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid && s_ready) begin
                    cmd.load = 1'b1;
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE: begin
                if (status.is_write) begin
                    cmd.write = 1'b1;
                    state_next = ST_IDLE;
                end else if (status.bad) begin
                    state_next = ST_OUT;
                end else begin
                    cmd.corner_start = 1'b1;
                    state_next = ST_CX;
                end
            end
            ST_CX: begin
                cmd.corner_step = 1'b1;
                if (status.corner_last) begin
                    state_next = ST_CXEND;
                end
            end
            ST_CXEND: begin
                cmd.acc_clear = 1'b1;
                state_next = ST_CYSTART;
            end
            ST_CYSTART: begin
                cmd.corner_start = 1'b1;
                cmd.corner_y = 1'b1;
                state_next = ST_CY;
            end
            ST_CY: begin
                cmd.corner_y = 1'b1;
                cmd.corner_step = 1'b1;
                if (status.corner_last) begin
                    state_next = ST_CYEND;
                end
            end
            ST_CYEND: begin
                cmd.acc_clear = 1'b1;
                cmd.corner_y = 1'b1;
                state_next = ST_READ;
            end
            ST_READ: begin
                cmd.acc_read = 1'b1;
                if (status.win_last) begin
                    state_next = ST_LAST;
                end
            end
            ST_LAST: begin
                cmd.acc_add = 1'b1;
                state_next = ST_DIV;
            end
            ST_DIV: begin
                cmd.div_start = 1'b1;
                state_next = ST_DIVGO;
            end
            ST_DIVGO: begin
                cmd.div_step = 1'b1;
                if (status.div_last) begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (!m_valid_reg) begin
                    cmd.out_load = 1'b1;
                    m_valid_next = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
        if (state_reg == ST_READ) begin
            cmd.acc_add = cmd.acc_add | rd_pend_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            m_valid_reg <= 1'b0;
            rd_pend_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            m_valid_reg <= m_valid_next;
            rd_pend_reg <= cmd.acc_read && (state_reg == ST_READ) && !status.win_last;
        end
    end
endmodule

@@ hw/rtl/box_filter_downscale_unit.sv @@
// A compute result is valid once the x and y corner divisions, the k*k window reads and
// the average division are done, k the effective window side; a bad coordinate skips them.
// A write is stored from the decode state. One word is handled at a time and the next
// waits until the result word is taken; the k*k window reads and 16-step dividers set the rate.
// Synchronous active-low reset restores the register defaults; the image memory is not
// cleared and holds undefined data until written. Depends on bfd_pkg, bfd_ctrl, bfd_datapath.
module box_filter_downscale_unit (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [2:0]                  cfg_index,
    input  logic [15:0]                 cfg_data,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic                        s_req_type,
    input  logic [bfd_pkg::CoordW-1:0]  s_coord_x,
    input  logic [bfd_pkg::CoordW-1:0]  s_coord_y,
    input  logic [bfd_pkg::PixW-1:0]    s_src_pixel,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [bfd_pkg::PixW-1:0]    m_avg_pixel,
    output logic                        m_bad_coord
);
    import bfd_pkg::*;

    bfd_cmd_t cmd;
    bfd_status_t status;

    assign cfg_ready = 1'b1;

    bfd_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn), .s_valid(s_valid), .s_ready(s_ready),
        .m_valid(m_valid), .m_ready(m_ready), .status(status), .cmd(cmd)
    );

    bfd_datapath u_dp (
        .aclk(aclk), .aresetn(aresetn), .cfg_valid(cfg_valid), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .s_req_type(s_req_type), .s_coord_x(s_coord_x),
        .s_coord_y(s_coord_y), .s_src_pixel(s_src_pixel), .cmd(cmd), .status(status),
        .avg_pixel(m_avg_pixel), .bad_coord(m_bad_coord)
    );
endmodule

@@ hw/rtl/bfd_checker.sv @@
// Port-level checker for the box filter downscale unit, bound to the top level.
// Depends on box_filter_downscale_unit.
module bfd_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic        m_valid,
    input logic        m_ready,
    input logic [23:0] m_avg_pixel,
    input logic        m_bad_coord
);
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_avg_pixel))
        else $error("result word changed while stalled");
    a_bad_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_bad_coord |-> m_avg_pixel == 24'd0)
        else $error("bad coordinate with nonzero pixel");
    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("word accepted while busy");
    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");
endmodule

bind box_filter_downscale_unit bfd_checker u_bfd_checker (
    .aclk(aclk), .aresetn(aresetn), .s_valid(s_valid), .s_ready(s_ready),
    .m_valid(m_valid), .m_ready(m_ready), .m_avg_pixel(m_avg_pixel),
    .m_bad_coord(m_bad_coord)
);
